[rtl/kwm_pkg.sv]
// Shared types, codes and default sizes of the k-way merge block.
`default_nettype none

package kwm_pkg;

    // Field widths of the transfer payloads
    localparam int OP_W     = 2;
    localparam int ID_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int POS_W    = 11;

    // Default sizes
    localparam int NUM_LISTS_DEF  = 8;
    localparam int LIST_DEPTH_DEF = 256;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } kwm_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_REFUSED = 2'd3
    } kwm_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_RD,
        S_SCAN,
        S_POP_WB,
        S_DONE
    } kwm_state_t;

    typedef struct packed {
        logic [OP_W-1:0]           opcode;
        logic [ID_W-1:0]           list_id;
        logic signed [VALUE_W-1:0] value;
    } kwm_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] out_value;
        logic [ID_W-1:0]           out_list;
        logic [INDEX_W-1:0]        out_index;
        logic [POS_W-1:0]          out_position;
        logic                      out_last;
    } kwm_out_t;

endpackage

`default_nettype wire

[rtl/kwm_stream_if.sv]
// Valid/ready stream interface carrying one payload per transfer.
`default_nettype none

interface kwm_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

[rtl/kwm_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module kwm_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read into a registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/kwm_ctrl.sv]
// Sequencer of the merge: loads, head scan over the list memory, write-back, result register.
`default_nettype none

module kwm_ctrl
    import kwm_pkg::*;
#(
    parameter int  NUM_LISTS  = NUM_LISTS_DEF,
    parameter int  LIST_DEPTH = LIST_DEPTH_DEF,
    localparam int LW = $clog2(LIST_DEPTH + 1),
    localparam int NW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1,
    localparam int CW = $clog2(NUM_LISTS + 1),
    localparam int SD = NUM_LISTS * LIST_DEPTH,
    localparam int AW = (SD > 1) ? $clog2(SD) : 1,
    localparam int TW = $clog2(SD + 1),
    localparam int MW = 2 * LW
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    kwm_stream_if.sink              items,
    kwm_stream_if.source            results,
    // value store
    output logic                    store_we,
    output logic [AW-1:0]           store_waddr,
    output logic [VALUE_W-1:0]      store_wdata,
    output logic [AW-1:0]           store_raddr,
    input  wire logic [VALUE_W-1:0] store_rdata,
    // length/head memory, length in the upper half
    output logic                    meta_we,
    output logic [NW-1:0]           meta_waddr,
    output logic [MW-1:0]           meta_wdata,
    output logic [NW-1:0]           meta_raddr,
    input  wire logic [MW-1:0]      meta_rdata
);

    // Slot of entry e of list l in the value store
    function automatic logic [AW-1:0] slot(input logic [NW-1:0] l, input logic [LW-1:0] e);
        slot = AW'(32'(l) * 32'(LIST_DEPTH) + 32'(e));
    endfunction

    kwm_state_t state_reg, state_next;

    logic                  draining_reg, draining_next;
    logic [TW-1:0]         total_reg, total_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [NUM_LISTS-1:0]  valid_reg, valid_next;
    logic                  meta_vq_reg, meta_vq_next;
    logic [CW-1:0]         rd_cnt_reg, rd_cnt_next;
    logic                  s1_vld_reg, s1_vld_next;
    logic                  s2_vld_reg, s2_vld_next;
    logic                  found_reg, found_next;
    logic                  out_valid_reg, out_valid_next;

    logic [NW-1:0]         id_reg, id_next;
    logic [VALUE_W-1:0]    val_reg, val_next;
    logic [NW-1:0]         s1_list_reg, s1_list_next;
    logic [NW-1:0]         s2_list_reg, s2_list_next;
    logic                  s2_live_reg, s2_live_next;
    logic [LW-1:0]         s2_head_reg, s2_head_next;
    logic [LW-1:0]         s2_len_reg, s2_len_next;
    logic [VALUE_W-1:0]    best_value_reg, best_value_next;
    logic [NW-1:0]         best_list_reg, best_list_next;
    logic [LW-1:0]         best_head_reg, best_head_next;
    logic [LW-1:0]         best_len_reg, best_len_next;
    kwm_out_t              res_reg, res_next;
    kwm_out_t              out_data_reg, out_data_next;

    logic                  accept;
    logic                  out_free;
    logic                  id_bad;
    logic [7:0]            id_wide;
    logic [NW-1:0]         id_idx;
    logic [LW-1:0]         meta_len;
    logic [LW-1:0]         meta_head;
    logic                  meta_live;
    logic                  scan_last;

    assign accept    = items.valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || results.ready;
    assign id_wide   = 8'(items.data.list_id);
    assign id_idx    = id_wide[NW-1:0];
    assign id_bad    = int'(items.data.list_id) >= NUM_LISTS;

    // Unwritten list entries read as empty
    assign meta_len  = meta_vq_reg ? meta_rdata[MW-1:LW] : '0;
    assign meta_head = meta_vq_reg ? meta_rdata[LW-1:0]  : '0;
    assign meta_live = meta_head < meta_len;
    assign scan_last = s2_vld_reg && (s2_list_reg == NW'(NUM_LISTS - 1));

    assign items.ready   = (state_reg == S_IDLE);
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (items.valid)
                begin
                    unique case (items.data.opcode)
                        OP_LOAD:
                        begin
                            if (draining_reg || id_bad)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_LOAD_RD;
                            end
                        end
                        OP_POP:
                        begin
                            if (total_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_LOAD_RD:
            begin
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_POP_WB;
                end
            end
            S_POP_WB:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and result
    always_comb
    begin
        draining_next   = draining_reg;
        total_next      = total_reg;
        pos_next        = pos_reg;
        valid_next      = valid_reg;
        rd_cnt_next     = rd_cnt_reg;
        s1_vld_next     = 1'b0;
        s2_vld_next     = 1'b0;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg;
        id_next         = id_reg;
        val_next        = val_reg;
        s1_list_next    = s1_list_reg;
        s2_list_next    = s2_list_reg;
        s2_live_next    = s2_live_reg;
        s2_head_next    = s2_head_reg;
        s2_len_next     = s2_len_reg;
        best_value_next = best_value_reg;
        best_list_next  = best_list_reg;
        best_head_next  = best_head_reg;
        best_len_next   = best_len_reg;
        res_next        = res_reg;
        out_data_next   = out_data_reg;
        store_we        = 1'b0;
        store_waddr     = '0;
        store_wdata     = val_reg;
        store_raddr     = '0;
        meta_we         = 1'b0;
        meta_waddr      = '0;
        meta_wdata      = '0;
        meta_raddr      = '0;

        // Drop the result once transferred
        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    id_next  = id_idx;
                    val_next = items.data.value;
                    res_next = '0;
                    unique case (items.data.opcode)
                        OP_LOAD:
                        begin
                            if (draining_reg)
                            begin
                                res_next.status = ST_REFUSED;
                            end
                            else if (id_bad)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                meta_raddr = id_idx;
                            end
                        end
                        OP_POP:
                        begin
                            draining_next = 1'b1;
                            rd_cnt_next   = '0;
                            found_next    = 1'b0;
                            if (total_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                        end
                        OP_CLEAR:
                        begin
                            valid_next    = '0;
                            total_next    = '0;
                            pos_next      = '0;
                            draining_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LOAD_RD:
            begin
                if (int'(meta_len) >= LIST_DEPTH)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    store_we            = 1'b1;
                    store_waddr         = slot(id_reg, meta_len);
                    meta_we             = 1'b1;
                    meta_waddr          = id_reg;
                    meta_wdata          = {meta_len + LW'(1), meta_head};
                    valid_next[id_reg]  = 1'b1;
                    total_next          = total_reg + TW'(1);
                end
            end
            S_SCAN:
            begin
                // Issue the length/head read of the next list
                if (int'(rd_cnt_reg) < NUM_LISTS)
                begin
                    meta_raddr   = rd_cnt_reg[NW-1:0];
                    s1_vld_next  = 1'b1;
                    s1_list_next = rd_cnt_reg[NW-1:0];
                    rd_cnt_next  = rd_cnt_reg + CW'(1);
                end
                // Fetch the head value of the list whose length/head arrived
                if (s1_vld_reg)
                begin
                    store_raddr  = slot(s1_list_reg, meta_live ? meta_head : '0);
                    s2_vld_next  = 1'b1;
                    s2_list_next = s1_list_reg;
                    s2_live_next = meta_live;
                    s2_head_next = meta_head;
                    s2_len_next  = meta_len;
                end
                // Keep the smallest head, later lists win ties
                if (s2_vld_reg && s2_live_reg)
                begin
                    if (!found_reg || ($signed(store_rdata) <= $signed(best_value_reg)))
                    begin
                        found_next      = 1'b1;
                        best_value_next = store_rdata;
                        best_list_next  = s2_list_reg;
                        best_head_next  = s2_head_reg;
                        best_len_next   = s2_len_reg;
                    end
                end
            end
            S_POP_WB:
            begin
                meta_we               = 1'b1;
                meta_waddr            = best_list_reg;
                meta_wdata            = {best_len_reg, best_head_reg + LW'(1)};
                total_next            = total_reg - TW'(1);
                pos_next              = pos_reg + POS_W'(1);
                res_next.status       = ST_OK;
                res_next.out_value    = best_value_reg;
                res_next.out_list     = ID_W'(best_list_reg);
                res_next.out_index    = INDEX_W'(best_head_reg);
                res_next.out_position = pos_reg;
                res_next.out_last     = (total_reg == TW'(1));
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Capture the valid bit of the list being read
    assign meta_vq_next = valid_reg[meta_raddr];

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            draining_reg  <= 1'b0;
            total_reg     <= '0;
            pos_reg       <= '0;
            valid_reg     <= '0;
            meta_vq_reg   <= 1'b0;
            rd_cnt_reg    <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            draining_reg  <= draining_next;
            total_reg     <= total_next;
            pos_reg       <= pos_next;
            valid_reg     <= valid_next;
            meta_vq_reg   <= meta_vq_next;
            rd_cnt_reg    <= rd_cnt_next;
            s1_vld_reg    <= s1_vld_next;
            s2_vld_reg    <= s2_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        id_reg         <= id_next;
        val_reg        <= val_next;
        s1_list_reg    <= s1_list_next;
        s2_list_reg    <= s2_list_next;
        s2_live_reg    <= s2_live_next;
        s2_head_reg    <= s2_head_next;
        s2_len_reg     <= s2_len_next;
        best_value_reg <= best_value_next;
        best_list_reg  <= best_list_next;
        best_head_reg  <= best_head_next;
        best_len_reg   <= best_len_next;
        res_reg        <= res_next;
        out_data_reg   <= out_data_next;
    end

endmodule

`default_nettype wire

[rtl/k_way_merge_with_origin_tags.sv]
// K-way merge with origin tags: the top level.
//
// Channels: items (sink) carries opcode, list_id and value; results (source)
// carries one result per item: status, out_value, out_list, out_index,
// out_position and out_last. A transfer takes place when valid and ready are
// both high at a rising edge of clk.
// Loads append a value to a list in the value store (NUM_LISTS*LIST_DEPTH
// words). A pop walks the length/head memory one list per cycle, fetches each
// live head from the value store in the cycle after its length/head read,
// keeps the smallest (the higher list on ties) and writes the advanced head
// back. A pop goes through the scan and the write-back, a load (also into a
// full list) through a length/head read, before the result is registered;
// a clear, a no-op, a pop with nothing left or a load refused while draining
// or to an out-of-range list goes straight to the result register. A pop is
// paced by the one-list-per-cycle read port of the length/head memory. A
// finished result waits in the output register while the next item is taken;
// when the receiver stalls with a result still held, the block holds the new
// result and accepts nothing further until that transfer completes.
// Reset (rst_n, asynchronous, active low) empties all lists, clears the
// position counter and the draining flag; the value store is not swept.
`default_nettype none

module k_way_merge_with_origin_tags
    import kwm_pkg::*;
#(
    parameter int NUM_LISTS  = NUM_LISTS_DEF,
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    kwm_stream_if.sink   items,
    kwm_stream_if.source results
);

    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam int NW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int SD = NUM_LISTS * LIST_DEPTH;
    localparam int AW = (SD > 1) ? $clog2(SD) : 1;
    localparam int MW = 2 * LW;

    logic               store_we;
    logic [AW-1:0]      store_waddr;
    logic [VALUE_W-1:0] store_wdata;
    logic [AW-1:0]      store_raddr;
    logic [VALUE_W-1:0] store_rdata;
    logic               meta_we;
    logic [NW-1:0]      meta_waddr;
    logic [MW-1:0]      meta_wdata;
    logic [NW-1:0]      meta_raddr;
    logic [MW-1:0]      meta_rdata;

    // Sequencer
    kwm_ctrl #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items),
        .results     (results),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .store_wdata (store_wdata),
        .store_raddr (store_raddr),
        .store_rdata (store_rdata),
        .meta_we     (meta_we),
        .meta_waddr  (meta_waddr),
        .meta_wdata  (meta_wdata),
        .meta_raddr  (meta_raddr),
        .meta_rdata  (meta_rdata)
    );

    // Value store
    kwm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SD)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // Per-list length and head
    kwm_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_LISTS)
    ) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

endmodule

`default_nettype wire

[rtl/kwm_checker.sv]
// Port-level checks of the merge block and their bind to the top level.
`default_nettype none

module kwm_checker
    import kwm_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     items_valid,
    input wire logic     items_ready,
    input wire logic     results_valid,
    input wire logic     results_ready,
    input wire kwm_out_t results_data
);

    // Hold a result until it is transferred
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=> results_valid)
        else $error("result dropped before transfer");

    // Take one item at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        items_valid && items_ready |=> !items_ready)
        else $error("item taken while another is in work");

    // Zero the tags on every result with a failure status
    a_tags_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && (results_data.status != ST_OK) |->
            (results_data.out_value == '0) && (results_data.out_list == '0) &&
            (results_data.out_index == '0) && (results_data.out_position == '0))
        else $error("tags set on a failed operation");

    // Flag the last element only on a result with OK status
    a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && results_data.out_last |-> (results_data.status == ST_OK))
        else $error("last flag with a failure status");

endmodule

bind k_way_merge_with_origin_tags kwm_checker u_kwm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .items_valid   (items.valid),
    .items_ready   (items.ready),
    .results_valid (results.valid),
    .results_ready (results.ready),
    .results_data  (results.data)
);

`default_nettype wire

[tb/tb_k_way_merge_with_origin_tags.sv]
// Testbench for the k-way merge: load/pop/clear traffic checked against a predictor.
`timescale 1ns / 100ps

module tb_k_way_merge_with_origin_tags;
    import kwm_pkg::*;

    localparam int LISTS       = NUM_LISTS_DEF;
    localparam int DEPTH       = LIST_DEPTH_DEF;
    localparam int ITEM_TARGET = 1610;
    localparam int QUIET_TAIL  = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;

    logic clk = 1'b0;
    logic rst_n;

    kwm_stream_if #(.payload_t(kwm_in_t))  items_if ();
    kwm_stream_if #(.payload_t(kwm_out_t)) results_if ();

    k_way_merge_with_origin_tags dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    // Pending commands and merge results still owed by the block
    kwm_in_t     item_backlog [$];
    kwm_out_t    expected_results [$];
    int          counted_items = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;

    // Shadow copy of the list memory and merge progress
    logic [31:0] list_words [0:LISTS*DEPTH-1];
    int unsigned list_len [LISTS];
    int unsigned list_rd [LISTS];
    logic [10:0] merge_pos = '0;
    bit          merge_locked = 1'b0;

    // Handshake flag seen at the last rising edge, and the drivers' idle controls
    logic        in_taken = 1'b0;
    int          src_gap = 0;
    int          snk_gap = 0;
    int          calm_left = 0;
    bit          may_idle;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Compute the result of one command and advance the shadow lists
    function automatic kwm_out_t merge_predict(kwm_in_t item);
        kwm_out_t           res;
        int                 best;
        int                 n;
        logic signed [31:0] head_val;
        logic signed [31:0] best_val;
        res = '0;
        best_val = '0;
        case (item.opcode)
            OP_LOAD:
            begin
                if (merge_locked)
                    res.status = ST_REFUSED;
                else if (item.list_id >= LISTS || list_len[item.list_id] >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    list_words[item.list_id * DEPTH + list_len[item.list_id]] = item.value;
                    list_len[item.list_id]++;
                end
            end
            OP_POP:
            begin
                merge_locked = 1'b1;
                best = -1;
                // Smallest head wins; on a tie the higher list takes it
                for (n = 0; n < LISTS; n++)
                    if (list_rd[n] < list_len[n])
                    begin
                        head_val = list_words[n * DEPTH + list_rd[n]];
                        if (best < 0 || head_val <= best_val)
                        begin
                            best = n;
                            best_val = head_val;
                        end
                    end
                if (best < 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.out_value    = best_val;
                    res.out_list     = best[2:0];
                    res.out_index    = 8'(list_rd[best]);
                    res.out_position = merge_pos;
                    list_rd[best]++;
                    merge_pos = merge_pos + 1'b1;
                    res.out_last = 1'b1;
                    for (n = 0; n < LISTS; n++)
                        if (list_rd[n] < list_len[n])
                            res.out_last = 1'b0;
                end
            end
            OP_CLEAR:
            begin
                for (n = 0; n < LISTS; n++)
                begin
                    list_len[n] = 0;
                    list_rd[n] = 0;
                end
                merge_pos = '0;
                merge_locked = 1'b0;
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    task automatic check_field(string field, logic [31:0] want_bits, logic [31:0] got_bits);
        if (want_bits !== got_bits)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_bits,
                     got_bits);
            mismatch_count++;
        end
    endtask

    task automatic queue_item(kwm_op_t op, int id, int value);
        kwm_in_t item;
        item.opcode  = op;
        item.list_id = id[2:0];
        item.value   = value;
        item_backlog.push_back(item);
        counted_items++;
    endtask

    task automatic queue_noise(int count);
        int k;
        for (k = 0; k < count; k++)
            queue_item(kwm_op_t'($urandom_range(0, 3)), $urandom, $urandom);
    endtask

    // Clear, fill lists with ascending runs, then drain them (fully or in part)
    task automatic queue_merge_round(int max_per_list, bit narrow, int full_list);
        int          words [LISTS][DEPTH];
        int          count [LISTS];
        int          sent [LISTS];
        int          total;
        int          left;
        int          pick;
        int          pops;
        int          n;
        int          k;
        int          swap;
        longint      v;
        int unsigned step_max;
        queue_item(OP_CLEAR, $urandom, $urandom);
        total = 0;
        step_max = 0;
        for (n = 0; n < LISTS; n++)
        begin
            if (n == full_list)
                count[n] = DEPTH;
            else if ($urandom_range(0, 3) == 0)
                count[n] = 0;
            else
                count[n] = $urandom_range(1, max_per_list);
            sent[n] = 0;
            // Narrow runs start near zero so that heads tie often
            v = narrow ? longint'($urandom_range(0, 8)) - 4 : longint'(int'($urandom));
            for (k = 0; k < count[n]; k++)
            begin
                if (k == 0)
                    step_max = 32'((64'sd2147483647 - v) / count[n]);
                else
                    v += narrow ? $urandom_range(0, 2) : $urandom_range(0, step_max);
                words[n][k] = int'(v);
            end
            // Break the order of a list now and then
            if (count[n] > 1 && $urandom_range(0, 9) == 0)
            begin
                swap = words[n][0];
                words[n][0] = words[n][count[n] - 1];
                words[n][count[n] - 1] = swap;
            end
            total += count[n];
        end
        left = total;
        while (left > 0)
        begin
            pick = $urandom_range(0, LISTS - 1);
            if (sent[pick] < count[pick])
            begin
                queue_item(OP_LOAD, pick, words[pick][sent[pick]]);
                sent[pick]++;
                left--;
            end
        end
        if (full_list >= 0)
            for (k = 0; k < 2; k++)
                queue_item(OP_LOAD, full_list, $urandom);
        if ($urandom_range(0, 5) == 0)
            pops = $urandom_range(0, total);
        else
            pops = total + $urandom_range(0, 2);
        for (k = 0; k < pops; k++)
        begin
            queue_item(OP_POP, $urandom, $urandom);
            if ($urandom_range(0, 11) == 0)
                queue_item($urandom_range(0, 1) ? OP_LOAD : OP_NOP, $urandom, $urandom);
        end
    endtask

    // Drive commands and result backpressure on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 119) == 0)
                calm_left = $urandom_range(30, 150);
            may_idle = calm_left == 0 && item_backlog.size() > QUIET_TAIL;

            if (!items_if.valid || in_taken)
            begin
                if (src_gap > 0)
                begin
                    items_if.valid <= 1'b0;
                    src_gap--;
                end
                else if (item_backlog.size() != 0 && may_idle && $urandom_range(0, 7) == 0)
                begin
                    items_if.valid <= 1'b0;
                    src_gap = $urandom_range(0, 13);
                end
                else if (item_backlog.size() != 0)
                begin
                    items_if.data  <= item_backlog.pop_front();
                    items_if.valid <= 1'b1;
                end
                else
                    items_if.valid <= 1'b0;
            end

            if (snk_gap > 0)
            begin
                results_if.ready <= 1'b0;
                snk_gap--;
            end
            else if (may_idle && $urandom_range(0, 7) == 0)
            begin
                results_if.ready <= 1'b0;
                snk_gap = $urandom_range(0, 13);
            end
            else
                results_if.ready <= 1'b1;
        end
    end

    // Sample transfers on the rising edge: predict on input, check on output
    always @(posedge clk)
    begin
        kwm_out_t want;
        in_taken <= items_if.valid && items_if.ready;
        if (items_if.valid && items_if.ready)
            expected_results.push_back(merge_predict(items_if.data));
        if (results_if.valid && results_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time,
                         results_if.data);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(results_if.data.status));
                check_field("out_value", want.out_value, results_if.data.out_value);
                check_field("out_list", 32'(want.out_list), 32'(results_if.data.out_list));
                check_field("out_index", 32'(want.out_index),
                            32'(results_if.data.out_index));
                check_field("out_position", 32'(want.out_position),
                            32'(results_if.data.out_position));
                check_field("out_last", 32'(want.out_last), 32'(results_if.data.out_last));
            end
        end
        if (!rst_n || (items_if.valid && items_if.ready)
            || (results_if.valid && results_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    // Stop a hung run
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("k_way_merge_with_origin_tags test failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        items_if.valid = 1'b0;
        items_if.data = '0;
        results_if.ready = 1'b0;

        // Directed: empty pop, refused load, extremes, ties, disorder, last flag
        queue_item(OP_POP, 7, -1);
        queue_item(OP_LOAD, 2, 5);
        queue_item(OP_NOP, 7, -1);
        queue_item(OP_CLEAR, 0, 0);
        queue_item(OP_LOAD, 0, int'(32'h8000_0000));
        queue_item(OP_LOAD, 0, -1);
        queue_item(OP_LOAD, 7, int'(32'h7FFF_FFFF));
        queue_item(OP_LOAD, 3, 0);
        queue_item(OP_LOAD, 5, 0);
        queue_item(OP_LOAD, 3, 0);
        queue_item(OP_LOAD, 2, 100);
        queue_item(OP_LOAD, 2, 50);
        queue_item(OP_LOAD, 6, -1);
        repeat (10)
            queue_item(OP_POP, 0, 0);
        queue_item(OP_LOAD, 4, 1);
        queue_item(OP_CLEAR, 7, -1);

        // Random: one round that fills a list past its depth, then mixed rounds
        queue_merge_round(12, 1'b0, $urandom_range(0, LISTS - 1));
        while (counted_items < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:       queue_noise($urandom_range(8, 30));
                1, 2:    queue_merge_round(8, 1'b1, -1);
                default: queue_merge_round(12, 1'b0, -1);
            endcase
        end

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for all commands to go in and all results to come back
        while (item_backlog.size() != 0 || items_if.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("k_way_merge_with_origin_tags test passed");
        else
            $display("k_way_merge_with_origin_tags test failed");
        $finish;
    end

endmodule

[k_way_merge_with_origin_tags.f]
rtl/kwm_pkg.sv
rtl/kwm_stream_if.sv
rtl/kwm_ram.sv
rtl/kwm_ctrl.sv
rtl/k_way_merge_with_origin_tags.sv
rtl/kwm_checker.sv
tb/tb_k_way_merge_with_origin_tags.sv
